// ===== sv/cmap_pkg.sv =====
// Shared types and constants for the constellation mapper.
`timescale 1ns / 1ps

package cmap_pkg;

  // Modulation codes held in the mode register
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_BPSK  = 2'd0;
  localparam mode_t MODE_QPSK  = 2'd1;
  localparam mode_t MODE_QAM16 = 2'd2;
  localparam mode_t MODE_SAT   = 2'd3;

  // Field widths
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned NBITS_W = 4;
  localparam int unsigned IQ_W    = 16;

  // Largest meaningful bit count; larger counts clamp to it
  localparam logic [NBITS_W-1:0] NBITS_MAX = 4'd8;

  // Q2.14 amplitude levels
  localparam logic signed [IQ_W-1:0] Q_ZERO      = 16'sd0;
  localparam logic signed [IQ_W-1:0] Q_ONE       = 16'sd16384;
  localparam logic signed [IQ_W-1:0] Q_THIRD     = 16'sd5461;
  localparam logic signed [IQ_W-1:0] Q_NEG_ONE   = -16'sd16384;
  localparam logic signed [IQ_W-1:0] Q_NEG_THIRD = -16'sd5461;

  typedef struct packed {
    logic signed [IQ_W-1:0] i_value;
    logic signed [IQ_W-1:0] q_value;
  } point_t;

endpackage

// ===== sv/cmap_if.sv =====
// Handshake interfaces for the mapper input, result and mode register channels.
`timescale 1ns / 1ps

interface cmap_in_if;
  logic                            valid;
  logic                            ready;
  logic [cmap_pkg::DATA_W-1:0]     data_byte;
  logic [cmap_pkg::NBITS_W-1:0]    bits_valid;

  modport source (output valid, output data_byte, output bits_valid, input ready);
  modport sink   (input valid, input data_byte, input bits_valid, output ready);
endinterface

interface cmap_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cmap_pkg::IQ_W-1:0]  i_value;
  logic signed [cmap_pkg::IQ_W-1:0]  q_value;
  logic                              last_of_byte;

  modport source (output valid, output i_value, output q_value, output last_of_byte,
                  input ready);
  modport sink   (input valid, input i_value, input q_value, input last_of_byte,
                  output ready);
endinterface

interface cmap_cfg_if;
  logic                 valid;
  logic                 ready;
  cmap_pkg::mode_t      data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/cmap_slicer.sv =====
// Symbol table: maps one group of bits to an I/Q point for the current mode.
`timescale 1ns / 1ps

module cmap_slicer (
  input  cmap_pkg::mode_t   mode,
  input  logic [3:0]        group,
  output cmap_pkg::point_t  point
);

  always_comb begin
    point.i_value = cmap_pkg::Q_ZERO;
    point.q_value = cmap_pkg::Q_ZERO;
    unique case (mode)
      cmap_pkg::MODE_BPSK: begin
        point.i_value = group[0] ? cmap_pkg::Q_ONE : cmap_pkg::Q_NEG_ONE;
      end
      cmap_pkg::MODE_QPSK: begin
        case (group[1:0])
          2'd0:    point.q_value = cmap_pkg::Q_ONE;
          2'd1:    point.i_value = cmap_pkg::Q_ONE;
          2'd2:    point.q_value = cmap_pkg::Q_NEG_ONE;
          default: point.i_value = cmap_pkg::Q_NEG_ONE;
        endcase
      end
      default: begin
        // 16-QAM: low pair picks I, high pair picks Q
        case (group[1:0])
          2'd0:    point.i_value = cmap_pkg::Q_NEG_ONE;
          2'd1:    point.i_value = cmap_pkg::Q_NEG_THIRD;
          2'd2:    point.i_value = cmap_pkg::Q_ONE;
          default: point.i_value = cmap_pkg::Q_THIRD;
        endcase
        case (group[3:2])
          2'd0:    point.q_value = cmap_pkg::Q_ONE;
          2'd1:    point.q_value = cmap_pkg::Q_THIRD;
          2'd2:    point.q_value = cmap_pkg::Q_NEG_ONE;
          default: point.q_value = cmap_pkg::Q_NEG_THIRD;
        endcase
      end
    endcase
  end

endmodule

// ===== sv/constellation_mapper_bpsk_qpsk_qam16.sv =====
// Top level of the BPSK / QPSK / 16-QAM constellation mapper.
//
//   channel  | dir | payload                              | request
//   ---------+-----+--------------------------------------+-------------------------
//   in_ch    | in  | data_byte[7:0], bits_valid[3:0]      | one byte of packed bits
//   out_ch   | out | i_value[15:0], q_value[15:0], last   | one constellation point
//   cfg_ch   | in  | data[1:0] (mode)                     | one mode register write
//
// A byte sits in the hold register and yields one point per cycle unless the output
// stalls, clamped bits_valid / group width points in all; hold_cnt_r counts them.
// A new byte is taken in the cycle its final point moves to the output register.
// Synchronous active-low reset clears the mode to BPSK and empties both stages.
// A stalled output holds its point and freezes the hold register behind it.
`timescale 1ns / 1ps

module constellation_mapper_bpsk_qpsk_qam16 (
  input  logic         clk,
  input  logic         rst_n,
  cmap_in_if.sink      in_ch,
  cmap_out_if.source   out_ch,
  cmap_cfg_if.sink     cfg_ch
);

  // Mode register; a write of the unused code saturates to 16-QAM
  cmap_pkg::mode_t mode_r;
  cmap_pkg::mode_t mode_nxt;

  assign cfg_ch.ready = 1'b1;
  assign mode_nxt = (cfg_ch.data == cmap_pkg::MODE_SAT) ? cmap_pkg::MODE_QAM16 : cfg_ch.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cmap_pkg::MODE_BPSK;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      mode_r <= mode_nxt;
    end
  end

  // Hold register: remaining bits of the current byte and how many points are left
  logic                             hold_vld_r;
  logic [cmap_pkg::DATA_W-1:0]      hold_data_r;
  logic [cmap_pkg::NBITS_W-1:0]     hold_cnt_r;
  logic [cmap_pkg::DATA_W-1:0]      hold_data_nxt;

  // Output register
  logic                             out_vld_r;
  cmap_pkg::point_t                 out_pt_r;
  logic                             out_last_r;

  logic                             advance;
  logic                             last_sym;
  logic                             accept;
  logic [cmap_pkg::NBITS_W-1:0]     nbits_sat;
  logic [cmap_pkg::NBITS_W-1:0]     sym_count;
  cmap_pkg::point_t                 point;

  // Clamp the bit count, then divide by the group width
  assign nbits_sat = (in_ch.bits_valid > cmap_pkg::NBITS_MAX) ? cmap_pkg::NBITS_MAX
                                                              : in_ch.bits_valid;

  always_comb begin
    unique case (mode_r)
      cmap_pkg::MODE_BPSK: begin
        sym_count     = nbits_sat;
        hold_data_nxt = hold_data_r >> 1;
      end
      cmap_pkg::MODE_QPSK: begin
        sym_count     = nbits_sat >> 1;
        hold_data_nxt = hold_data_r >> 2;
      end
      default: begin
        sym_count     = nbits_sat >> 2;
        hold_data_nxt = hold_data_r >> 4;
      end
    endcase
  end

  // Move a point forward when the output slot is free or being emptied
  assign advance  = hold_vld_r && (!out_vld_r || out_ch.ready);
  assign last_sym = (hold_cnt_r == 4'd1);
  assign in_ch.ready = !hold_vld_r || (advance && last_sym);
  assign accept   = in_ch.valid && in_ch.ready;

  cmap_slicer u_slicer (
    .mode  (mode_r),
    .group (hold_data_r[3:0]),
    .point (point)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (accept) begin
      // A byte too short for one group yields nothing: drop it
      hold_vld_r <= (sym_count != '0);
    end else if (advance && last_sym) begin
      hold_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_data_r <= in_ch.data_byte;
      hold_cnt_r  <= sym_count;
    end else if (advance) begin
      hold_data_r <= hold_data_nxt;
      hold_cnt_r  <= hold_cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pt_r   <= point;
      out_last_r <= last_sym;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.i_value      = out_pt_r.i_value;
  assign out_ch.q_value      = out_pt_r.q_value;
  assign out_ch.last_of_byte = out_last_r;

endmodule

// ===== tb/tb_constellation_mapper_bpsk_qpsk_qam16.sv =====
// Self-checking testbench for the BPSK / QPSK / 16-QAM constellation mapper.
`timescale 1ns / 1ps

module tb_constellation_mapper_bpsk_qpsk_qam16;

  // Run limit in cycles.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Cycles to let a byte that makes no point clear the hold and output stages.
  localparam int unsigned SETTLE_CYCLES = 16;
  // Random bytes per mode phase.
  localparam int unsigned PHASE_BYTES = 33;

  typedef logic [cmap_pkg::NBITS_W-1:0] nbits_t;

  typedef struct {
    logic signed [cmap_pkg::IQ_W-1:0] i_value;
    logic signed [cmap_pkg::IQ_W-1:0] q_value;
    logic                             last_of_byte;
  } sym_t;

  logic clk;
  logic rst_n;

  cmap_in_if  in_ch ();
  cmap_out_if out_ch ();
  cmap_cfg_if cfg_ch ();

  constellation_mapper_bpsk_qpsk_qam16 u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Points still owed by the block, oldest first.
  sym_t            pending_syms[$];
  // Mode as the block should hold it, tracked from accepted register writes.
  cmap_pkg::mode_t mode_now;
  int unsigned     fail_cnt;
  int unsigned     cycle_cnt;
  // No idling on either side while this is set.
  logic            no_idle;
  // Receiver hold-off request in cycles; taken and cleared by the receiver.
  int unsigned     hold_off_req;

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Work out the points that one byte yields under the given mode and queue them.
  function automatic void queue_points(input cmap_pkg::mode_t m,
                                       input logic [cmap_pkg::DATA_W-1:0] d,
                                       input nbits_t n);
    int unsigned nb;
    int unsigned w;
    int unsigned cnt;
    logic [3:0]  g;
    sym_t        s;
    nb = (n > cmap_pkg::NBITS_MAX) ? cmap_pkg::NBITS_MAX : n;
    case (m)
      cmap_pkg::MODE_BPSK: w = 1;
      cmap_pkg::MODE_QPSK: w = 2;
      default:             w = 4;
    endcase
    cnt = nb / w;
    for (int unsigned k = 0; k < cnt; k++) begin
      g = 4'((d >> (k * w)) & ((1 << w) - 1));
      case (m)
        cmap_pkg::MODE_BPSK: begin
          s.i_value = g[0] ? cmap_pkg::Q_ONE : cmap_pkg::Q_NEG_ONE;
          s.q_value = cmap_pkg::Q_ZERO;
        end
        cmap_pkg::MODE_QPSK: begin
          case (g[1:0])
            2'd0: begin
              s.i_value = cmap_pkg::Q_ZERO;
              s.q_value = cmap_pkg::Q_ONE;
            end
            2'd1: begin
              s.i_value = cmap_pkg::Q_ONE;
              s.q_value = cmap_pkg::Q_ZERO;
            end
            2'd2: begin
              s.i_value = cmap_pkg::Q_ZERO;
              s.q_value = cmap_pkg::Q_NEG_ONE;
            end
            default: begin
              s.i_value = cmap_pkg::Q_NEG_ONE;
              s.q_value = cmap_pkg::Q_ZERO;
            end
          endcase
        end
        default: begin
          // 16-QAM: low pair picks I, high pair picks Q
          case (g[1:0])
            2'd0:    s.i_value = cmap_pkg::Q_NEG_ONE;
            2'd1:    s.i_value = cmap_pkg::Q_NEG_THIRD;
            2'd2:    s.i_value = cmap_pkg::Q_ONE;
            default: s.i_value = cmap_pkg::Q_THIRD;
          endcase
          case (g[3:2])
            2'd0:    s.q_value = cmap_pkg::Q_ONE;
            2'd1:    s.q_value = cmap_pkg::Q_THIRD;
            2'd2:    s.q_value = cmap_pkg::Q_NEG_ONE;
            default: s.q_value = cmap_pkg::Q_NEG_THIRD;
          endcase
        end
      endcase
      s.last_of_byte = (k + 1 == cnt);
      pending_syms.push_back(s);
    end
  endfunction

  // Sender gap: mostly none, sometimes short, now and then long.
  function automatic int unsigned send_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sample both channels and the register port at the rising edge; predict on every
  // accepted byte, check every accepted point against the oldest expectation.
  always @(posedge clk) begin
    sym_t exp_s;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready)
        mode_now = (cfg_ch.data == cmap_pkg::MODE_SAT) ? cmap_pkg::MODE_QAM16
                                                       : cfg_ch.data;
      if (in_ch.valid && in_ch.ready)
        queue_points(mode_now, in_ch.data_byte, in_ch.bits_valid);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_syms.size() == 0) begin
          $error("point with nothing expected: i_value %0d q_value %0d last_of_byte %0b",
                 out_ch.i_value, out_ch.q_value, out_ch.last_of_byte);
          fail_cnt++;
        end else begin
          exp_s = pending_syms.pop_front();
          if (out_ch.i_value !== exp_s.i_value) begin
            $error("i_value: expected %0d, actual %0d", exp_s.i_value, out_ch.i_value);
            fail_cnt++;
          end
          if (out_ch.q_value !== exp_s.q_value) begin
            $error("q_value: expected %0d, actual %0d", exp_s.q_value, out_ch.q_value);
            fail_cnt++;
          end
          if (out_ch.last_of_byte !== exp_s.last_of_byte) begin
            $error("last_of_byte: expected %0b, actual %0b",
                   exp_s.last_of_byte, out_ch.last_of_byte);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: drive ready at the falling edge. Honour a hold-off request first, else
  // accept at random with low stretches that are mostly short and a few long.
  initial begin
    int unsigned n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req != 0) begin
        n = hold_off_req;
        hold_off_req = 0;
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else if (no_idle || $urandom_range(0, 99) < 65) begin
        out_ch.ready <= 1'b1;
      end else begin
        n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 30);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Offer one byte from a falling edge, hold it until the request is taken, then idle
  // for the given gap. With no gap, valid stays high for the next byte.
  task automatic send_byte(input logic [cmap_pkg::DATA_W-1:0] d, input nbits_t n,
                           input int unsigned gap);
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= d;
    in_ch.bits_valid <= n;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid and hold off until every owed point has arrived and the block has
  // had time to dispose of any byte that yields nothing.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (pending_syms.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the mode register while the block is idle.
  task automatic write_mode(input cmap_pkg::mode_t m);
    wait_drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mode after reset must be BPSK.
  task automatic test_reset_mode();
    send_byte(8'hA5, 4'd8, send_gap());
    send_byte(8'h00, 4'd1, send_gap());
  endtask

  // BPSK with all-ones, all-zeros, clamped counts and an empty count.
  task automatic test_bpsk_extremes();
    write_mode(cmap_pkg::MODE_BPSK);
    send_byte(8'hFF, 4'd8, send_gap());
    send_byte(8'h00, 4'd8, send_gap());
    send_byte(8'h5A, 4'd15, send_gap());
    send_byte(8'hFF, 4'd0, send_gap());
    send_byte(8'h3C, 4'd9, send_gap());
  endtask

  // QPSK: every dibit value, and partial groups that are dropped.
  task automatic test_qpsk();
    write_mode(cmap_pkg::MODE_QPSK);
    send_byte(8'hE4, 4'd8, send_gap());
    send_byte(8'h1B, 4'd8, send_gap());
    send_byte(8'hFE, 4'd3, send_gap());
    send_byte(8'hFF, 4'd1, send_gap());
  endtask

  // 16-QAM: all sixteen nibbles, a count too short for a group, a partial group and a
  // clamped count.
  task automatic test_qam16();
    write_mode(cmap_pkg::MODE_QAM16);
    for (int unsigned k = 0; k < 8; k++)
      send_byte(8'(((2 * k + 1) << 4) | (2 * k)), 4'd8, send_gap());
    send_byte(8'hFF, 4'd3, send_gap());
    send_byte(8'h9C, 4'd7, send_gap());
    send_byte(8'h6D, 4'd12, send_gap());
  endtask

  // A write of the top code must leave the block in 16-QAM.
  task automatic test_mode_saturation();
    write_mode(cmap_pkg::MODE_SAT);
    send_byte(8'hC3, 4'd8, send_gap());
  endtask

  // Hold the receiver off while bytes keep coming, so the block fills and stalls.
  task automatic test_backpressure();
    write_mode(cmap_pkg::mode_t'($urandom_range(0, 2)));
    hold_off_req = 150;
    for (int unsigned k = 0; k < 24; k++)
      send_byte(8'($urandom), cmap_pkg::NBITS_MAX, 0);
    wait_drain();
  endtask

  // Random bytes over several mode phases; most carry a full byte, the rest any count.
  task automatic test_random_traffic();
    nbits_t n;
    for (int unsigned ph = 0; ph < 7; ph++) begin
      write_mode(cmap_pkg::mode_t'($urandom_range(0, 3)));
      // one phase runs flat out on both sides
      no_idle = (ph == 3);
      for (int unsigned k = 0; k < PHASE_BYTES; k++) begin
        n = ($urandom_range(0, 99) < 70) ? cmap_pkg::NBITS_MAX
                                         : nbits_t'($urandom_range(0, 15));
        send_byte(8'($urandom), n, send_gap());
        // in one phase, pause mid-phase until the block has emptied
        if (k == PHASE_BYTES / 2 && ph == 5)
          wait_drain();
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.bits_valid = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = cmap_pkg::MODE_BPSK;
    mode_now         = cmap_pkg::MODE_BPSK;
    fail_cnt         = 0;
    cycle_cnt        = 0;
    no_idle          = 1'b0;
    hold_off_req     = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_mode();
    test_bpsk_extremes();
    test_qpsk();
    test_qam16();
    test_mode_saturation();
    test_backpressure();
    test_random_traffic();

    // Drain, then wait the settle time once more for anything unexpected to show up.
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
